// ----- src/tfb_pkg.sv -----
// Shared types, constants and rounding helpers for the tangent frame builder.
// No dependencies; every other file imports this package.
package tfb_pkg;

  localparam int Q_ONE   = 16384;
  localparam int Y_LIMIT = 16220;

  // Square root unit: radicand and root widths, one root bit per stage.
  localparam int ROOT_W   = 31;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQRT_LAT = ROOT_W;

  // Divider unit: one quotient bit per stage.
  localparam int DIV_Q_W   = 16;
  localparam int DIV_NUM_W = 46;
  localparam int DIV_DEN_W = ROOT_W;
  localparam int DIV_LAT   = DIV_Q_W;

  localparam logic signed [47:0] Q_ONE_W  = 48'(Q_ONE);
  localparam logic signed [15:0] Q_ONE_16 = 16'(Q_ONE);

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] rotation_x;
    logic signed [15:0] rotation_y;
    logic signed [15:0] rotation_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic signed [15:0] unit_normal_x;
    logic signed [15:0] unit_normal_y;
    logic signed [15:0] unit_normal_z;
    logic               degenerate;
  } out_t;

  // Divide by 2^14, round half away from zero.
  function automatic logic signed [47:0] rnd_q14(input logic signed [47:0] x);
    logic [47:0] mag;
    logic [47:0] q;
    mag = x[47] ? 48'(-x) : 48'(x);
    q   = (mag + 48'd8192) >> 14;
    return x[47] ? -$signed(q) : $signed(q);
  endfunction

  // Saturate to [-1.0, 1.0] in Q1.14.
  function automatic logic signed [15:0] clamp_q(input logic signed [47:0] x);
    logic signed [15:0] res;
    if (x > Q_ONE_W) begin
      res = Q_ONE_16;
    end else if (x < -Q_ONE_W) begin
      res = -Q_ONE_16;
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

endpackage

// ----- src/tfb_sqrt.sv -----
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on tfb_pkg for widths; its registers advance only while en is high.
module tfb_sqrt import tfb_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_in,
  output logic [ROOT_W-1:0] root_out
);

  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W:0]    trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_in;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign trial = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k]  <= rem_in - trial[RAD_W-1:0];
          root_r[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root_out = root_r[ROOT_W-1];

endmodule

// ----- src/tfb_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on tfb_pkg for widths; its registers advance only while en is high.
module tfb_div import tfb_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num_in,
  input  logic [DIV_DEN_W-1:0] den_in,
  output logic [DIV_Q_W-1:0]   quo_out
);

  logic [DIV_NUM_W-1:0] rem_r [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_r [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
    localparam int B = DIV_Q_W - 1 - k;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_cur;
    logic [DIV_Q_W-1:0]   quo_in;
    logic [DIV_NUM_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = num_in;
      assign den_cur = den_in;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign den_cur = den_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    assign trial = (DIV_NUM_W+1)'(den_cur) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_cur;
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k] <= rem_in - trial[DIV_NUM_W-1:0];
          quo_r[k] <= quo_in | (DIV_Q_W'(1) << B);
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
      end
    end
  end

  assign quo_out = quo_r[DIV_Q_W-1];

endmodule

// ----- src/tangent_frame_builder_core.sv -----
// Top level of the tangent frame builder: input/output registers and the datapath stages.
// Depends on tfb_pkg, tfb_sqrt and tfb_div.
//
// Builds an orthonormal tangent / bitangent / unit normal basis in Q1.14 from a
// normal and a rotation vector. Fully pipelined: one item is accepted every cycle
// while in_stall is low, and its path runs through the two square root pipelines
// (31 stages each) and the two restoring divider banks (16 stages each). The
// whole pipeline advances as one; it freezes only while a result sits in the
// output register and out_stall is high, so in_stall follows that condition and
// no item is dropped or repeated. Bubbles are carried by per-stage valid bits.
// A zero normal gives degenerate = 1 and all vector fields zero.
module tangent_frame_builder_core import tfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef struct packed {
    in_t  vec;
    logic degen;
  } sb_norm_t;

  typedef struct packed {
    logic [2:0][31:0] t;
    logic [2:0][15:0] u;
    logic             degen;
  } sb_tan_t;

  typedef struct packed {
    logic [2:0]       tsgn;
    logic [2:0][15:0] u;
    logic             degen;
    logic             lt_zero;
  } sb_quo_t;

  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- valid bits ----------------
  logic                va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r, vi_r, vj_r, vk_r;
  logic                vl_r, vm_r, vn_r, out_valid_r;
  logic [SQRT_LAT-1:0] v1_r, v3_r;
  logic [DIV_LAT-1:0]  v2_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0; ve_r <= 1'b0;
      vf_r <= 1'b0; vg_r <= 1'b0; vh_r <= 1'b0; vi_r <= 1'b0; vj_r <= 1'b0;
      vk_r <= 1'b0; vl_r <= 1'b0; vm_r <= 1'b0; vn_r <= 1'b0; out_valid_r <= 1'b0;
      v1_r <= '0; v2_r <= '0; v3_r <= '0; v4_r <= '0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      v1_r <= {v1_r[SQRT_LAT-2:0], vb_r};
      v2_r <= {v2_r[DIV_LAT-2:0], v1_r[SQRT_LAT-1]};
      vc_r <= v2_r[DIV_LAT-1];
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
      vi_r <= vh_r;
      vj_r <= vi_r;
      vk_r <= vj_r;
      v3_r <= {v3_r[SQRT_LAT-2:0], vk_r};
      v4_r <= {v4_r[DIV_LAT-2:0], v3_r[SQRT_LAT-1]};
      vl_r <= v4_r[DIV_LAT-1];
      vm_r <= vl_r;
      vn_r <= vm_r;
      out_valid_r <= vn_r;
    end
  end

  // ---------------- stage A: register item, square the normal ----------------
  in_t         a_in_r;
  logic [31:0] a_nsq_r [3];
  logic signed [15:0] nin [3];

  assign nin[0] = in_data.normal_x;
  assign nin[1] = in_data.normal_y;
  assign nin[2] = in_data.normal_z;

  always_ff @(posedge clk) begin
    if (en) begin
      a_in_r <= in_data;
      for (int i = 0; i < 3; i++) begin
        a_nsq_r[i] <= 32'(nin[i] * nin[i]);
      end
    end
  end

  // ---------------- stage B: squared length of the normal ----------------
  in_t         b_in_r;
  logic [31:0] b_s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_in_r <= a_in_r;
      b_s_r  <= a_nsq_r[0] + a_nsq_r[1] + a_nsq_r[2];
    end
  end

  // ---------------- normal length: Ln = isqrt(s * 2^28) ----------------
  logic [ROOT_W-1:0] ln;
  sb_norm_t          sb1_r [SQRT_LAT];

  tfb_sqrt u_sqrt_norm (
    .clk      (clk),
    .en       (en),
    .rad_in   (RAD_W'({b_s_r, 28'd0})),
    .root_out (ln)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r[0] <= '{vec: b_in_r, degen: (b_s_r == 32'd0)};
      for (int k = 1; k < SQRT_LAT; k++) begin
        sb1_r[k] <= sb1_r[k-1];
      end
    end
  end

  // ---------------- unit normal division ----------------
  sb_norm_t           sb1_o;
  logic signed [15:0] n1 [3];
  logic [DIV_Q_W-1:0] uq [3];
  sb_norm_t           sb2_r [DIV_LAT];

  assign sb1_o = sb1_r[SQRT_LAT-1];
  assign n1[0] = sb1_o.vec.normal_x;
  assign n1[1] = sb1_o.vec.normal_y;
  assign n1[2] = sb1_o.vec.normal_z;

  for (genvar i = 0; i < 3; i++) begin : g_div_norm
    logic [15:0] nmag;
    assign nmag = n1[i][15] ? 16'(-n1[i]) : 16'(n1[i]);
    tfb_div u_div (
      .clk     (clk),
      .en      (en),
      .num_in  (DIV_NUM_W'({nmag, 28'd0}) + DIV_NUM_W'(ln >> 1)),
      .den_in  (ln),
      .quo_out (uq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[0] <= sb1_o;
      for (int k = 1; k < DIV_LAT; k++) begin
        sb2_r[k] <= sb2_r[k-1];
      end
    end
  end

  // ---------------- stage C: sign, clamp and zero the unit normal ----------------
  sb_norm_t           sb2_o;
  logic [2:0]         nsgn2;
  logic signed [15:0] c_u_r [3];
  logic signed [15:0] c_r_r [3];
  logic               c_degen_r;

  assign sb2_o = sb2_r[DIV_LAT-1];
  assign nsgn2 = {sb2_o.vec.normal_z[15], sb2_o.vec.normal_y[15], sb2_o.vec.normal_x[15]};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_u_r[i] <= sb2_o.degen ? 16'sd0 :
                    clamp_q(nsgn2[i] ? -$signed(48'(uq[i])) : $signed(48'(uq[i])));
      end
      c_r_r[0]  <= sb2_o.vec.rotation_x;
      c_r_r[1]  <= sb2_o.vec.rotation_y;
      c_r_r[2]  <= sb2_o.vec.rotation_z;
      c_degen_r <= sb2_o.degen;
    end
  end

  // ---------------- stage D: r.u products and squares of u ----------------
  logic signed [31:0] d_p_r   [3];
  logic [28:0]        d_usq_r [3];
  logic signed [15:0] d_u_r   [3];
  logic signed [15:0] d_r_r   [3];
  logic               d_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_p_r[i]   <= c_r_r[i] * c_u_r[i];
        d_usq_r[i] <= 29'(c_u_r[i] * c_u_r[i]);
        d_u_r[i]   <= c_u_r[i];
        d_r_r[i]   <= c_r_r[i];
      end
      d_degen_r <= c_degen_r;
    end
  end

  // ---------------- stage E: dot product d ----------------
  logic signed [31:0] e_d_r;
  logic [28:0]        e_usq_r [3];
  logic signed [15:0] e_u_r   [3];
  logic signed [15:0] e_r_r   [3];
  logic               e_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_d_r     <= d_p_r[0] + d_p_r[1] + d_p_r[2];
      e_usq_r   <= d_usq_r;
      e_u_r     <= d_u_r;
      e_r_r     <= d_r_r;
      e_degen_r <= d_degen_r;
    end
  end

  // ---------------- stage F: u * d ----------------
  function automatic logic signed [47:0] f_mul(input logic signed [15:0] a,
                                               input logic signed [31:0] b);
    logic signed [47:0] aw;
    logic signed [47:0] bw;
    aw = 48'(a);
    bw = 48'(b);
    return aw * bw;
  endfunction

  logic signed [47:0] f_m_r   [3];
  logic [28:0]        f_usq_r [3];
  logic signed [15:0] f_u_r   [3];
  logic signed [15:0] f_r_r   [3];
  logic               f_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_m_r[i] <= 48'(f_mul(e_u_r[i], e_d_r));
      end
      f_usq_r   <= e_usq_r;
      f_u_r     <= e_u_r;
      f_r_r     <= e_r_r;
      f_degen_r <= e_degen_r;
    end
  end

  // ---------------- stage G: r*2^28 - u*d ----------------
  logic signed [47:0] g_diff_r [3];
  logic [28:0]        g_usq_r  [3];
  logic signed [15:0] g_u_r    [3];
  logic               g_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        g_diff_r[i] <= (48'(f_r_r[i]) <<< 28) - f_m_r[i];
      end
      g_usq_r   <= f_usq_r;
      g_u_r     <= f_u_r;
      g_degen_r <= f_degen_r;
    end
  end

  // ---------------- stage H: round to the Q28 tangent ----------------
  logic signed [31:0] h_t_r   [3];
  logic [28:0]        h_usq_r [3];
  logic signed [15:0] h_u_r   [3];
  logic               h_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h_t_r[i] <= 32'(rnd_q14(g_diff_r[i]));
      end
      h_usq_r   <= g_usq_r;
      h_u_r     <= g_u_r;
      h_degen_r <= g_degen_r;
    end
  end

  // ---------------- stage I: tangent squares, fallback axis ----------------
  logic [63:0]        i_sq_r  [3];
  logic signed [31:0] i_t_r   [3];
  logic [28:0]        i_usq_r [3];
  logic signed [15:0] i_u_r   [3];
  logic               i_up_r;
  logic               i_degen_r;
  logic [31:0]        htmag [3];
  logic [15:0]        uy_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      htmag[i] = h_t_r[i][31] ? 32'(-h_t_r[i]) : 32'(h_t_r[i]);
    end
    uy_mag = h_u_r[1][15] ? 16'(-h_u_r[1]) : 16'(h_u_r[1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        i_sq_r[i] <= 64'(htmag[i]) * 64'(htmag[i]);
      end
      i_t_r     <= h_t_r;
      i_usq_r   <= h_usq_r;
      i_u_r     <= h_u_r;
      i_up_r    <= (uy_mag <= 16'(Y_LIMIT));
      i_degen_r <= h_degen_r;
    end
  end

  // ---------------- stage J: squared tangent length ----------------
  logic [63:0]        j_tsq_r;
  logic signed [31:0] j_t_r   [3];
  logic [28:0]        j_usq_r [3];
  logic signed [15:0] j_u_r   [3];
  logic               j_up_r;
  logic               j_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      j_tsq_r   <= i_sq_r[0] + i_sq_r[1] + i_sq_r[2];
      j_t_r     <= i_t_r;
      j_usq_r   <= i_usq_r;
      j_u_r     <= i_u_r;
      j_up_r    <= i_up_r;
      j_degen_r <= i_degen_r;
    end
  end

  // ---------------- stage K: swap in the fallback tangent when too short ----------------
  logic [RAD_W-1:0]   k_tsq_r;
  logic signed [31:0] k_t_r [3];
  logic signed [15:0] k_u_r [3];
  logic               k_degen_r;
  logic               short_t;
  logic [29:0]        fb_sq;

  assign short_t = (j_tsq_r < 64'd268435456);
  assign fb_sq   = j_up_r ? 30'(j_usq_r[2]) + 30'(j_usq_r[0])
                          : 30'(j_usq_r[2]) + 30'(j_usq_r[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (short_t) begin
        k_tsq_r <= RAD_W'({fb_sq, 28'd0});
        if (j_up_r) begin
          k_t_r[0] <= 32'(j_u_r[2]) <<< 14;
          k_t_r[1] <= 32'sd0;
          k_t_r[2] <= -(32'(j_u_r[0]) <<< 14);
        end else begin
          k_t_r[0] <= 32'sd0;
          k_t_r[1] <= -(32'(j_u_r[2]) <<< 14);
          k_t_r[2] <= 32'(j_u_r[1]) <<< 14;
        end
      end else begin
        k_tsq_r <= j_tsq_r[RAD_W-1:0];
        k_t_r   <= j_t_r;
      end
      k_u_r     <= j_u_r;
      k_degen_r <= j_degen_r;
    end
  end

  // ---------------- tangent length: Lt = isqrt(tsq) ----------------
  logic [ROOT_W-1:0] lt;
  sb_tan_t           sb3_r [SQRT_LAT];

  tfb_sqrt u_sqrt_tan (
    .clk      (clk),
    .en       (en),
    .rad_in   (k_tsq_r),
    .root_out (lt)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r[0] <= '{t: {k_t_r[2], k_t_r[1], k_t_r[0]},
                    u: {k_u_r[2], k_u_r[1], k_u_r[0]},
                    degen: k_degen_r};
      for (int k = 1; k < SQRT_LAT; k++) begin
        sb3_r[k] <= sb3_r[k-1];
      end
    end
  end

  // ---------------- unit tangent division ----------------
  sb_tan_t            sb3_o;
  logic [DIV_Q_W-1:0] tq [3];
  logic [2:0]         tsgn3;
  sb_quo_t            sb4_r [DIV_LAT];

  assign sb3_o = sb3_r[SQRT_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_div_tan
    logic [31:0] tmag;
    assign tsgn3[i] = sb3_o.t[i][31];
    assign tmag     = sb3_o.t[i][31] ? 32'(-$signed(sb3_o.t[i])) : sb3_o.t[i];
    tfb_div u_div (
      .clk     (clk),
      .en      (en),
      .num_in  (DIV_NUM_W'({tmag, 14'd0}) + DIV_NUM_W'(lt >> 1)),
      .den_in  (lt),
      .quo_out (tq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb4_r[0] <= '{tsgn: tsgn3, u: sb3_o.u, degen: sb3_o.degen,
                    lt_zero: (lt == '0)};
      for (int k = 1; k < DIV_LAT; k++) begin
        sb4_r[k] <= sb4_r[k-1];
      end
    end
  end

  // ---------------- stage L: sign, clamp and zero the tangent ----------------
  sb_quo_t            sb4_o;
  logic signed [15:0] l_tan_r [3];
  logic signed [15:0] l_u_r   [3];
  logic               l_degen_r;

  assign sb4_o = sb4_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l_tan_r[i] <= (sb4_o.lt_zero || sb4_o.degen) ? 16'sd0 :
                      clamp_q(sb4_o.tsgn[i] ? -$signed(48'(tq[i])) : $signed(48'(tq[i])));
        l_u_r[i]   <= $signed(sb4_o.u[i]);
      end
      l_degen_r <= sb4_o.degen;
    end
  end

  // ---------------- stage M: cross product terms ----------------
  logic signed [31:0] m_c_r   [6];
  logic signed [15:0] m_tan_r [3];
  logic signed [15:0] m_u_r   [3];
  logic               m_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_c_r[0]  <= l_u_r[1] * l_tan_r[2];
      m_c_r[1]  <= l_u_r[2] * l_tan_r[1];
      m_c_r[2]  <= l_u_r[2] * l_tan_r[0];
      m_c_r[3]  <= l_u_r[0] * l_tan_r[2];
      m_c_r[4]  <= l_u_r[0] * l_tan_r[1];
      m_c_r[5]  <= l_u_r[1] * l_tan_r[0];
      m_tan_r   <= l_tan_r;
      m_u_r     <= l_u_r;
      m_degen_r <= l_degen_r;
    end
  end

  // ---------------- stage N: cross product differences ----------------
  logic signed [32:0] n_x_r   [3];
  logic signed [15:0] n_tan_r [3];
  logic signed [15:0] n_u_r   [3];
  logic               n_degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_x_r[i] <= 33'(m_c_r[2*i]) - 33'(m_c_r[2*i+1]);
      end
      n_tan_r   <= m_tan_r;
      n_u_r     <= m_u_r;
      n_degen_r <= m_degen_r;
    end
  end

  // ---------------- output register: round and clamp the bitangent ----------------
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.tangent_x     <= n_tan_r[0];
      out_data_r.tangent_y     <= n_tan_r[1];
      out_data_r.tangent_z     <= n_tan_r[2];
      out_data_r.bitangent_x   <= clamp_q(rnd_q14(48'(n_x_r[0])));
      out_data_r.bitangent_y   <= clamp_q(rnd_q14(48'(n_x_r[1])));
      out_data_r.bitangent_z   <= clamp_q(rnd_q14(48'(n_x_r[2])));
      out_data_r.unit_normal_x <= n_u_r[0];
      out_data_r.unit_normal_y <= n_u_r[1];
      out_data_r.unit_normal_z <= n_u_r[2];
      out_data_r.degenerate    <= n_degen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.degenerate |->
      out_data_r.tangent_x == 16'sd0 && out_data_r.tangent_y == 16'sd0 &&
      out_data_r.tangent_z == 16'sd0 && out_data_r.bitangent_x == 16'sd0 &&
      out_data_r.bitangent_y == 16'sd0 && out_data_r.bitangent_z == 16'sd0 &&
      out_data_r.unit_normal_x == 16'sd0 && out_data_r.unit_normal_y == 16'sd0 &&
      out_data_r.unit_normal_z == 16'sd0)
    else $error("degenerate item carries nonzero vectors");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.degenerate |->
      out_data_r.unit_normal_x != 16'sd0 || out_data_r.unit_normal_y != 16'sd0 ||
      out_data_r.unit_normal_z != 16'sd0)
    else $error("nonzero normal normalized to zero");

  a_lt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r[DIV_LAT-1] && !sb4_o.degen |-> !sb4_o.lt_zero)
    else $error("zero tangent length on a nonzero normal");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vc_r) && $stable(vl_r) && $stable(v1_r) && $stable(v4_r))
    else $error("pipeline moved while frozen");

endmodule

// ----- sim/tb_tangent_frame_builder_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tangent_frame_builder_core: directed table plus random items.
// Depends on tfb_pkg and the core RTL; predicts each basis in 64-bit integer math.
module tb_tangent_frame_builder_core;
  import tfb_pkg::*;

  localparam int PIPE_LAT   = 109;
  localparam int N_RANDOM   = 1800;
  localparam int MAX_REPORT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #6 clk = ~clk;

  tangent_frame_builder_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Expected bases, oldest first.
  out_t basis_fifo[$];
  int   mismatches = 0;
  bit   stim_done  = 1'b0;

  // Directed table: known-answer rows carry the expected basis.
  typedef struct {
    in_t  item;
    bit   known;
    out_t basis;
  } dir_row_t;

  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > Q_ONE) return Q_ONE;
    if (v < -Q_ONE) return -Q_ONE;
    return v;
  endfunction

  // Bitwise integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_t build_basis(in_t x);
    longint n[3], r[3], u[3], t[3], tg[3], bt[3];
    longint unsigned s, ln, tsq, lt;
    longint dot, ay;
    out_t o;
    n[0] = x.normal_x;   n[1] = x.normal_y;   n[2] = x.normal_z;
    r[0] = x.rotation_x; r[1] = x.rotation_y; r[2] = x.rotation_z;
    for (int i = 0; i < 3; i++) begin
      u[i] = 0; tg[i] = 0; bt[i] = 0;
    end
    s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    if (s != 0) begin
      ln = int_sqrt(s << 28);
      for (int i = 0; i < 3; i++) u[i] = sat_q(div_round(n[i] * 268435456, ln));
      dot = r[0] * u[0] + r[1] * u[1] + r[2] * u[2];
      for (int i = 0; i < 3; i++) t[i] = div_round(r[i] * 268435456 - u[i] * dot, 16384);
      tsq = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
      // Short tangent: swap in up x n, or right x n near the poles.
      if (tsq < (64'd1 << 28)) begin
        ay = (u[1] < 0) ? -u[1] : u[1];
        if (ay <= Y_LIMIT) begin
          t[0] = u[2] * 16384; t[1] = 0; t[2] = -u[0] * 16384;
        end else begin
          t[0] = 0; t[1] = -u[2] * 16384; t[2] = u[1] * 16384;
        end
        tsq = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
      end
      lt = int_sqrt(tsq);
      if (lt != 0) begin
        for (int i = 0; i < 3; i++) tg[i] = sat_q(div_round(t[i] * 16384, lt));
        bt[0] = sat_q(div_round(u[1] * tg[2] - u[2] * tg[1], 16384));
        bt[1] = sat_q(div_round(u[2] * tg[0] - u[0] * tg[2], 16384));
        bt[2] = sat_q(div_round(u[0] * tg[1] - u[1] * tg[0], 16384));
      end
    end
    o.tangent_x     = 16'(tg[0]); o.tangent_y     = 16'(tg[1]); o.tangent_z     = 16'(tg[2]);
    o.bitangent_x   = 16'(bt[0]); o.bitangent_y   = 16'(bt[1]); o.bitangent_z   = 16'(bt[2]);
    o.unit_normal_x = 16'(u[0]);  o.unit_normal_y = 16'(u[1]);  o.unit_normal_z = 16'(u[2]);
    o.degenerate    = (s == 0);
    return o;
  endfunction

  function automatic in_t mk_item(int nx, int ny, int nz, int rx, int ry, int rz);
    in_t x;
    x.normal_x = 16'(nx); x.normal_y = 16'(ny); x.normal_z = 16'(nz);
    x.rotation_x = 16'(rx); x.rotation_y = 16'(ry); x.rotation_z = 16'(rz);
    return x;
  endfunction

  function automatic out_t mk_basis(int tx, int ty, int tz, int bx, int by, int bz,
                                    int ux, int uy, int uz, bit dg);
    out_t o;
    o.tangent_x = 16'(tx); o.tangent_y = 16'(ty); o.tangent_z = 16'(tz);
    o.bitangent_x = 16'(bx); o.bitangent_y = 16'(by); o.bitangent_z = 16'(bz);
    o.unit_normal_x = 16'(ux); o.unit_normal_y = 16'(uy); o.unit_normal_z = 16'(uz);
    o.degenerate = dg;
    return o;
  endfunction

  // Short gaps mostly, an occasional long one, and runs of none.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_comp();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return -32768;
    if (p == 1) return 32767;
    if (p < 4) return int'($urandom_range(0, 64)) - 32;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Drive one item and hold it until accepted; drop valid only across a gap.
  task automatic send_item(in_t x, bit known, out_t basis);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    basis_fifo.push_back(known ? basis : build_basis(x));
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_fifo();
    while (basis_fifo.size() != 0) @(posedge clk);
  endtask

  // Receiver stall: independent random pattern with quiet stretches.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      hold = pick_gap();
      out_stall <= (hold != 0);
      repeat ((hold == 0) ? $urandom_range(1, 20) : hold) @(posedge clk);
    end
  end

  // Compare each accepted basis with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (basis_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("unexpected basis out %h at %0t", out_data, $realtime);
      end else begin
        want = basis_fifo.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("basis mismatch at %0t: exp t=(%0d %0d %0d) b=(%0d %0d %0d)",
              $realtime, want.tangent_x, want.tangent_y, want.tangent_z,
              want.bitangent_x, want.bitangent_y, want.bitangent_z,
              " u=(%0d %0d %0d) dg=%0b",
              want.unit_normal_x, want.unit_normal_y, want.unit_normal_z, want.degenerate,
              " got t=(%0d %0d %0d) b=(%0d %0d %0d)",
              out_data.tangent_x, out_data.tangent_y, out_data.tangent_z,
              out_data.bitangent_x, out_data.bitangent_y, out_data.bitangent_z,
              " u=(%0d %0d %0d) dg=%0b",
              out_data.unit_normal_x, out_data.unit_normal_y, out_data.unit_normal_z,
              out_data.degenerate);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t rows[$];
    out_t     none;
    in_t      x;
    int       nx, ny, nz, k;
    none = '0;
    // Zero normal: degenerate, all vectors zero.
    rows.push_back('{mk_item(0, 0, 0, 0, 0, 0), 1'b1, mk_basis(0,0,0,0,0,0,0,0,0,1)});
    rows.push_back('{mk_item(0, 0, 0, 32767, -32768, 5), 1'b1,
                     mk_basis(0,0,0,0,0,0,0,0,0,1)});
    // Axis normal with rotation along x: t = x, b = n x t.
    rows.push_back('{mk_item(0, 0, 16384, 16384, 0, 0), 1'b1,
                     mk_basis(16384,0,0, 0,16384,0, 0,0,16384, 0)});
    // Rotation parallel to normal falls back to up x n.
    rows.push_back('{mk_item(0, 0, 16384, 0, 0, 16384), 1'b1,
                     mk_basis(16384,0,0, 0,16384,0, 0,0,16384, 0)});
    // Zero rotation, normal near +y: right x n fallback.
    rows.push_back('{mk_item(0, 16384, 0, 0, 0, 0), 1'b1,
                     mk_basis(0,0,16384, 16384,0,0, 0,16384,0, 0)});
    rows.push_back('{mk_item(0, -32768, 0, 0, 0, 0), 0, none});
    // Field extremes and the 0.99 threshold neighborhood.
    rows.push_back('{mk_item(-32768, -32768, -32768, -32768, -32768, -32768), 0, none});
    rows.push_back('{mk_item(32767, 32767, 32767, 32767, 32767, 32767), 0, none});
    rows.push_back('{mk_item(32767, -32768, 1, -1, 32767, -32768), 0, none});
    rows.push_back('{mk_item(1, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(0, 0, -1, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(2310, 16220, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(2400, 16220, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(2200, -16230, 0, 0, 16384, 0), 0, none});
    rows.push_back('{mk_item(100, 200, 300, 100, 200, 301), 0, none});
    rows.push_back('{mk_item(-5000, 7000, 9000, 1, 0, -1), 0, none});
    rows.push_back('{mk_item(16384, 0, 0, 0, 16384, 16384), 0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].basis);
    // Let the pipeline empty once before the random part.
    in_valid <= 1'b0;
    drain_fifo();

    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(0, 9);
      nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
      x = mk_item(nx, ny, nz, rand_comp(), rand_comp(), rand_comp());
      // Rotation along the normal exercises the short tangent path.
      if (k == 0) begin
        x.rotation_x = x.normal_x; x.rotation_y = x.normal_y; x.rotation_z = x.normal_z;
      end else if (k == 1) begin
        x.normal_x = 16'(int'($urandom_range(0, 400)) - 200);
        x.normal_z = 16'(int'($urandom_range(0, 400)) - 200);
      end else if (k == 2) begin
        x.normal_x = '0; x.normal_y = '0; x.normal_z = '0;
      end
      send_item(x, 1'b0, none);
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        drain_fifo();
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Finish once everything has arrived and the pipe has had time to flush.
  initial begin
    wait (stim_done);
    drain_fifo();
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (mismatches == 0 && basis_fifo.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 2000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tfb_pkg.sv
src/tfb_sqrt.sv
src/tfb_div.sv
src/tangent_frame_builder_core.sv
sim/tb_tangent_frame_builder_core.sv
